[rtl/euler_pivot_transform_compose_unit_defines.svh]
// Assertion macros used by the top-level RTL of the pose transform unit.
// Depends on nothing; files that check their logic include it by name.
`ifndef EULER_PIVOT_TRANSFORM_COMPOSE_UNIT_DEFINES_SVH
`define EULER_PIVOT_TRANSFORM_COMPOSE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define EPCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define EPCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EPCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EPCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/epct_pkg.sv]
// Types, constants and shared functions of the pose transform unit.
// Depends on nothing; every other RTL file but the assertion header imports it.
package epct_pkg;

    // angle units: 1/64 degree
    localparam int ANG_FULL = 23040;
    localparam int ANG_QUAD = 5760;
    localparam int ANG_OCT  = 2880;

    localparam logic [18:0] RAD_K = 19'd292818;

    // Q1.30 series coefficients
    localparam logic [30:0] Q30_ONE  = 31'd1073741824;
    localparam logic [30:0] K_S6     = 31'd178956971;
    localparam logic [30:0] K_S120   = 31'd8947849;
    localparam logic [30:0] K_S5040  = 31'd213044;
    localparam logic [30:0] K_C2     = 31'd536870912;
    localparam logic [30:0] K_C24    = 31'd44739243;
    localparam logic [30:0] K_C720   = 31'd1491308;
    localparam logic [30:0] K_C40320 = 31'd26631;

    localparam int Q14_ONE   = 16384;
    localparam int TRANS_MAX = 8388607;
    localparam int TRANS_MIN = -8388608;

    // stage counts
    localparam int SC_LAT     = 9;
    localparam int ROT_LAT    = 3;
    localparam int CMP_LAT    = 4;
    localparam int CARRY_LEN  = SC_LAT + ROT_LAT;
    localparam int PIPE_DEPTH = SC_LAT + ROT_LAT + CMP_LAT;
    localparam int N_ANG      = 6;

    typedef enum logic [1:0] {
        CFG_TORSO_ANGLES = 2'd0,
        CFG_TORSO_PIVOT  = 2'd1,
        CFG_TORSO_OFFSET = 2'd2
    } t_cfg_idx;

    typedef logic signed [15:0] t_q14;
    typedef logic signed [15:0] t_q8;
    typedef logic signed [23:0] t_mv;
    typedef t_q14 t_mat [9];
    typedef t_q8  t_vec [3];
    typedef t_mv  t_mvec [3];

    typedef struct packed {
        logic               rotate_enable;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [15:0] pivot_x;
        logic signed [15:0] pivot_y;
        logic signed [15:0] pivot_z;
        logic               torso_enable;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [23:0] move_x;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [23:0] move_y;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [23:0] move_z;
    } t_out_word;

    // per-item control and pivot, carried alongside the trig pipeline
    typedef struct packed {
        logic               rot_en;
        logic               tor_en;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
    } t_carry;

    // unsigned Q30 product, truncated
    function automatic logic [30:0] qmul(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b);
        return p[60:30];
    endfunction

endpackage

[rtl/epct_in_if.sv]
// Input channel of the pose transform unit: one pose word per handshake.
// Depends on epct_pkg for the word type.
interface epct_in_if import epct_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/epct_out_if.sv]
// Output channel of the pose transform unit: one 3x4 transform per handshake.
// Depends on epct_pkg for the word type.
interface epct_out_if import epct_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/epct_sincos.sv]
// Pipelined sine and cosine of a 1/64 degree angle, Q14 results, nine stages.
// Depends on epct_pkg for constants and the Q30 multiply.
module epct_sincos import epct_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output t_q14               o_sin,
    output t_q14               o_cos
);
    typedef struct packed {
        logic [1:0] q;
        logic       mir;
    } t_quad;

    logic signed [17:0] a_ext;
    logic signed [17:0] a_w1;
    logic signed [17:0] a_wrap;
    logic [14:0]        n_m;
    logic [14:0]        r_m;

    logic [14:0] q_base;
    logic [12:0] rem;
    t_quad       n_qm;
    logic [11:0] n_rp;
    logic [11:0] r_rp;
    t_quad       r_qm [7];

    logic [30:0] r_t  [5];
    logic [30:0] r_t2 [4];
    logic [30:0] r_s1, r_c1, r_s2, r_c2, r_s3, r_c3, r_sp, r_cp;

    logic [31:0]        w_s, w_c;
    logic signed [15:0] ss, cc, sa, ca;
    t_q14               n_sin, n_cos, r_sin, r_cos;

    // reduce to [0, full turn)
    always_comb begin
        a_ext = 18'(i_angle);
        a_w1  = a_ext;
        if (a_ext < 0) begin
            a_w1 = a_ext + 18'(ANG_FULL);
            if (a_w1 < 0) begin
                a_wrap = a_w1 + 18'(ANG_FULL);
            end else begin
                a_wrap = a_w1;
            end
        end else if (a_ext >= 18'(ANG_FULL)) begin
            a_wrap = a_ext - 18'(ANG_FULL);
        end else begin
            a_wrap = a_ext;
        end
        n_m = a_wrap[14:0];
    end

    // quadrant, remainder, fold about the octant
    always_comb begin
        if (r_m >= 15'(3 * ANG_QUAD)) begin
            n_qm.q = 2'd3;
            q_base = 15'(3 * ANG_QUAD);
        end else if (r_m >= 15'(2 * ANG_QUAD)) begin
            n_qm.q = 2'd2;
            q_base = 15'(2 * ANG_QUAD);
        end else if (r_m >= 15'(ANG_QUAD)) begin
            n_qm.q = 2'd1;
            q_base = 15'(ANG_QUAD);
        end else begin
            n_qm.q = 2'd0;
            q_base = '0;
        end
        rem       = 13'(r_m - q_base);
        n_qm.mir  = rem > 13'(ANG_OCT);
        n_rp      = n_qm.mir ? 12'(13'(ANG_QUAD) - rem) : rem[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m      <= n_m;
            r_qm[0]  <= n_qm;
            r_rp     <= n_rp;
            for (int i = 1; i < 7; i++) begin
                r_qm[i] <= r_qm[i-1];
            end
            r_t[0]   <= 31'(r_rp * RAD_K);
            for (int i = 1; i < 5; i++) begin
                r_t[i] <= r_t[i-1];
            end
            r_t2[0]  <= qmul(r_t[0], r_t[0]);
            for (int i = 1; i < 4; i++) begin
                r_t2[i] <= r_t2[i-1];
            end
            r_s1     <= K_S120 - qmul(r_t2[0], K_S5040);
            r_c1     <= K_C720 - qmul(r_t2[0], K_C40320);
            r_s2     <= K_S6 - qmul(r_t2[1], r_s1);
            r_c2     <= K_C24 - qmul(r_t2[1], r_c1);
            r_s3     <= Q30_ONE - qmul(r_t2[2], r_s2);
            r_c3     <= K_C2 - qmul(r_t2[2], r_c2);
            r_sp     <= qmul(r_t[4], r_s3);
            r_cp     <= Q30_ONE - qmul(r_t2[3], r_c3);
            r_sin    <= n_sin;
            r_cos    <= n_cos;
        end
    end

    // round to Q14, undo the fold and place in the quadrant
    always_comb begin
        w_s = 32'(r_sp) + 32'd32768;
        w_c = 32'(r_cp) + 32'd32768;
        ss  = $signed({1'b0, w_s[30:16]});
        cc  = $signed({1'b0, w_c[30:16]});
        sa  = r_qm[6].mir ? cc : ss;
        ca  = r_qm[6].mir ? ss : cc;
        case (r_qm[6].q)
            2'd0: begin
                n_sin = sa;
                n_cos = ca;
            end
            2'd1: begin
                n_sin = ca;
                n_cos = -sa;
            end
            2'd2: begin
                n_sin = -sa;
                n_cos = -ca;
            end
            default: begin
                n_sin = -ca;
                n_cos = sa;
            end
        endcase
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[rtl/epct_rot.sv]
// Rz*Ry*Rx rotation matrix from Q14 sines and cosines, three stages.
// Depends on epct_pkg for the Q14 and matrix types.
module epct_rot import epct_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_q14 i_sx,
    input  t_q14 i_cx,
    input  t_q14 i_sy,
    input  t_q14 i_cy,
    input  t_q14 i_sz,
    input  t_q14 i_cz,
    output t_mat o_m
);
    logic signed [29:0] r_cycz, r_sxsy, r_cxsz, r_sxsz, r_cxcz;
    logic signed [29:0] r_cysz, r_cxsy, r_czsx, r_cysx, r_cxcy;
    t_q14               r_sy, r_sz, r_cz;
    logic signed [44:0] n_v [9];
    logic signed [44:0] r_v [9];
    t_mat               r_m;

    function automatic logic signed [44:0] k14(input logic signed [29:0] v);
        return {v[29], v, 14'd0};
    endfunction

    function automatic t_q14 rnd_clamp28(input logic signed [44:0] v);
        logic signed [45:0] w;
        logic signed [17:0] s;
        w = 46'(v) + 46'sd134217728;
        s = $signed(w[45:28]);
        if (s > 18'(Q14_ONE)) begin
            return 16'(Q14_ONE);
        end else if (s < -18'(Q14_ONE)) begin
            return -16'(Q14_ONE);
        end
        return s[15:0];
    endfunction

    always_comb begin
        n_v[0] = k14(r_cycz);
        n_v[1] = 45'(r_cz) * 45'(r_sxsy) - k14(r_cxsz);
        n_v[2] = k14(r_sxsz) + 45'(r_sy) * 45'(r_cxcz);
        n_v[3] = k14(r_cysz);
        n_v[4] = k14(r_cxcz) + 45'(r_sz) * 45'(r_sxsy);
        n_v[5] = 45'(r_sz) * 45'(r_cxsy) - k14(r_czsx);
        n_v[6] = -$signed({r_sy[15], r_sy, 28'd0});
        n_v[7] = k14(r_cysx);
        n_v[8] = k14(r_cxcy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz <= 30'(i_cy * i_cz);
            r_sxsy <= 30'(i_sx * i_sy);
            r_cxsz <= 30'(i_cx * i_sz);
            r_sxsz <= 30'(i_sx * i_sz);
            r_cxcz <= 30'(i_cx * i_cz);
            r_cysz <= 30'(i_cy * i_sz);
            r_cxsy <= 30'(i_cx * i_sy);
            r_czsx <= 30'(i_cz * i_sx);
            r_cysx <= 30'(i_cy * i_sx);
            r_cxcy <= 30'(i_cx * i_cy);
            r_sy   <= i_sy;
            r_sz   <= i_sz;
            r_cz   <= i_cz;
            for (int i = 0; i < 9; i++) begin
                r_v[i] <= n_v[i];
                r_m[i] <= rnd_clamp28(r_v[i]);
            end
        end
    end

    assign o_m = r_m;

endmodule

[rtl/epct_cmp.sv]
// Pivot translation and torso composition, four stages ending in the result register.
// Depends on epct_pkg for matrix, vector, carry and output types.
module epct_cmp import epct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_carry    i_ctl,
    input  t_mat      i_r,
    input  t_mat      i_tm,
    input  t_vec      i_tp,
    input  t_vec      i_off,
    output t_out_word o_word
);
    logic signed [31:0] r_pr [3][3];
    logic signed [29:0] r_tr [3][3][3];
    t_mat               r_r1, r_r2, r_r3, r_tm1, r_tm2;
    t_carry             r_ctl1, r_ctl2, r_ctl3;

    t_mv                n_t [3];
    t_q14               n_fm [9];
    t_mv                r_t2v [3];
    t_mv                r_t3v [3];
    t_mat               r_fm2, r_fm3;
    logic signed [35:0] r_mt [3][3];

    t_q8                pv [3];
    logic signed [32:0] acc_t;
    logic signed [31:0] acc_m;
    logic signed [37:0] acc_f;
    t_mv                n_ft [3];
    t_out_word          n_word, r_word;

    function automatic t_q14 rnd_clamp14(input logic signed [31:0] v);
        logic signed [32:0] w;
        logic signed [18:0] s;
        w = 33'(v) + 33'sd8192;
        s = $signed(w[32:14]);
        if (s > 19'(Q14_ONE)) begin
            return 16'(Q14_ONE);
        end else if (s < -19'(Q14_ONE)) begin
            return -16'(Q14_ONE);
        end
        return s[15:0];
    endfunction

    function automatic t_mv rnd_sat24(input logic signed [39:0] v);
        logic signed [40:0] w;
        logic signed [26:0] s;
        w = 41'(v) + 41'sd8192;
        s = $signed(w[40:14]);
        if (s > 27'(TRANS_MAX)) begin
            return 24'(TRANS_MAX);
        end else if (s < 27'(TRANS_MIN)) begin
            return 24'(TRANS_MIN);
        end
        return s[23:0];
    endfunction

    always_comb begin
        pv[0] = r_ctl1.px;
        pv[1] = r_ctl1.py;
        pv[2] = r_ctl1.pz;
        acc_t = '0;
        acc_m = '0;
        for (int i = 0; i < 3; i++) begin
            acc_t = $signed({pv[i][15], pv[i], 14'd0}) - 33'(r_pr[i][0])
                    - 33'(r_pr[i][1]) - 33'(r_pr[i][2]);
            n_t[i] = rnd_sat24(40'(acc_t));
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc_m = 32'(r_tr[i][j][0]) + 32'(r_tr[i][j][1]) + 32'(r_tr[i][j][2]);
                n_fm[i*3+j] = rnd_clamp14(acc_m);
            end
        end
    end

    // final translation and choice between identity, part and composed transform
    always_comb begin
        acc_f = '0;
        for (int i = 0; i < 3; i++) begin
            acc_f = $signed({{6{i_tp[i][15]}}, i_tp[i], 14'd0})
                    + $signed({{6{i_off[i][15]}}, i_off[i], 14'd0})
                    + 38'(r_mt[i][0]) + 38'(r_mt[i][1]) + 38'(r_mt[i][2]);
            n_ft[i] = rnd_sat24(40'(acc_f));
        end
        if (!r_ctl3.rot_en) begin
            n_word = '0;
            n_word.m00 = 16'(Q14_ONE);
            n_word.m11 = 16'(Q14_ONE);
            n_word.m22 = 16'(Q14_ONE);
        end else if (r_ctl3.tor_en) begin
            n_word = '{m00: r_fm3[0], m01: r_fm3[1], m02: r_fm3[2], move_x: n_ft[0],
                       m10: r_fm3[3], m11: r_fm3[4], m12: r_fm3[5], move_y: n_ft[1],
                       m20: r_fm3[6], m21: r_fm3[7], m22: r_fm3[8], move_z: n_ft[2]};
        end else begin
            n_word = '{m00: r_r3[0], m01: r_r3[1], m02: r_r3[2], move_x: r_t3v[0],
                       m10: r_r3[3], m11: r_r3[4], m12: r_r3[5], move_y: r_t3v[1],
                       m20: r_r3[6], m21: r_r3[7], m22: r_r3[8], move_z: r_t3v[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products of the part matrix with the pivot and of torso with part
            r_pr[0][0] <= 32'(i_r[0] * i_ctl.px);
            r_pr[0][1] <= 32'(i_r[1] * i_ctl.py);
            r_pr[0][2] <= 32'(i_r[2] * i_ctl.pz);
            r_pr[1][0] <= 32'(i_r[3] * i_ctl.px);
            r_pr[1][1] <= 32'(i_r[4] * i_ctl.py);
            r_pr[1][2] <= 32'(i_r[5] * i_ctl.pz);
            r_pr[2][0] <= 32'(i_r[6] * i_ctl.px);
            r_pr[2][1] <= 32'(i_r[7] * i_ctl.py);
            r_pr[2][2] <= 32'(i_r[8] * i_ctl.pz);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_tr[i][j][k] <= 30'(i_tm[i*3+k] * i_r[k*3+j]);
                    end
                end
            end
            r_r1   <= i_r;
            r_tm1  <= i_tm;
            r_ctl1 <= i_ctl;

            r_t2v  <= n_t;
            r_fm2  <= n_fm;
            r_r2   <= r_r1;
            r_tm2  <= r_tm1;
            r_ctl2 <= r_ctl1;

            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_mt[i][k] <= 36'(r_tm2[i*3+k] * (25'(r_t2v[k]) - 25'(i_tp[k])));
                end
            end
            r_t3v  <= r_t2v;
            r_fm3  <= r_fm2;
            r_r3   <= r_r2;
            r_ctl3 <= r_ctl2;

            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

[rtl/euler_pivot_transform_compose_unit.sv]
// An accepted pose word passes the sine/cosine, rotation and composition stages to the output.
// Throughput: one word per cycle; the pipeline advances as a whole and holds when
// the output register is full and not taken, so input ready is high when it is empty or taken.
// Reset clears the stage valid bits and the three torso registers to zero.
`include "euler_pivot_transform_compose_unit_defines.svh"
module euler_pivot_transform_compose_unit import epct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    epct_in_if.sink     i_item,
    epct_out_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    logic [47:0]           r_torso_angles, r_torso_pivot, r_torso_offset;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_carry                r_carry [CARRY_LEN];
    t_carry                n_carry;
    logic                  w_en;

    logic signed [15:0]    w_ang [N_ANG];
    t_q14                  w_sin [N_ANG];
    t_q14                  w_cos [N_ANG];
    t_mat                  w_rp, w_rt;
    t_vec                  w_tp, w_off;
    t_out_word             w_word;

    assign w_en         = ~r_vld[PIPE_DEPTH-1] | o_res.ready;
    assign i_item.ready = w_en;
    assign o_res.valid  = r_vld[PIPE_DEPTH-1];
    assign o_res.data   = w_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_torso_angles <= '0;
            r_torso_pivot  <= '0;
            r_torso_offset <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TORSO_ANGLES: r_torso_angles <= i_cfg_data;
                CFG_TORSO_PIVOT:  r_torso_pivot  <= i_cfg_data;
                CFG_TORSO_OFFSET: r_torso_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_item.valid};
        end
    end

    assign n_carry = '{rot_en: i_item.data.rotate_enable, tor_en: i_item.data.torso_enable,
                       px: i_item.data.pivot_x, py: i_item.data.pivot_y,
                       pz: i_item.data.pivot_z};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_carry[0] <= n_carry;
            for (int i = 1; i < CARRY_LEN; i++) begin
                r_carry[i] <= r_carry[i-1];
            end
        end
    end

    assign w_ang[0] = i_item.data.angle_x;
    assign w_ang[1] = i_item.data.angle_y;
    assign w_ang[2] = i_item.data.angle_z;
    assign w_ang[3] = $signed(r_torso_angles[15:0]);
    assign w_ang[4] = $signed(r_torso_angles[31:16]);
    assign w_ang[5] = $signed(r_torso_angles[47:32]);

    assign w_tp[0]  = $signed(r_torso_pivot[15:0]);
    assign w_tp[1]  = $signed(r_torso_pivot[31:16]);
    assign w_tp[2]  = $signed(r_torso_pivot[47:32]);
    assign w_off[0] = $signed(r_torso_offset[15:0]);
    assign w_off[1] = $signed(r_torso_offset[31:16]);
    assign w_off[2] = $signed(r_torso_offset[47:32]);

    for (genvar g = 0; g < N_ANG; g++) begin : g_trig
        epct_sincos u_sincos (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (w_ang[g]),
            .o_sin   (w_sin[g]),
            .o_cos   (w_cos[g])
        );
    end

    epct_rot u_rot_part (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_sx  (w_sin[0]),
        .i_cx  (w_cos[0]),
        .i_sy  (w_sin[1]),
        .i_cy  (w_cos[1]),
        .i_sz  (w_sin[2]),
        .i_cz  (w_cos[2]),
        .o_m   (w_rp)
    );

    epct_rot u_rot_torso (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_sx  (w_sin[3]),
        .i_cx  (w_cos[3]),
        .i_sy  (w_sin[4]),
        .i_cy  (w_cos[4]),
        .i_sz  (w_sin[5]),
        .i_cz  (w_cos[5]),
        .o_m   (w_rt)
    );

    epct_cmp u_cmp (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_ctl  (r_carry[CARRY_LEN-1]),
        .i_r    (w_rp),
        .i_tm   (w_rt),
        .i_tp   (w_tp),
        .i_off  (w_off),
        .o_word (w_word)
    );

    `EPCT_ASSERT_NXT(a_hold_on_stall, i_clk, i_rst_n, !w_en, $stable(r_vld))
    `EPCT_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_item.valid && i_item.ready, r_vld[0])
    `EPCT_ASSERT_IMP(a_empty_tail_ready, i_clk, i_rst_n, !o_res.valid, i_item.ready)

endmodule

[tb/sv/epct_tb_pkg.sv]
// Pose transform predictor for the testbench of the pose transform unit.
// Depends on epct_pkg for the word types.
`timescale 1ns / 1ps
package epct_tb_pkg;
    import epct_pkg::*;

    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return longint'(p >> 30);
    endfunction

    // sine and cosine in Q14 from an angle in 1/64 degree
    function automatic void angle_trig(input longint a, output longint s, output longint c);
        longint m, q, r, t, t2, sp, cp, ss, cc, tmp;
        m = a % 23040;
        if (m < 0) m += 23040;
        q = m / 5760;
        r = m % 5760;
        tmp = 0;
        if (r > 2880) r = 5760 - r;
        t = r * 292818;
        t2 = q30_mul(t, t);
        sp = q30_mul(t, 1073741824 - q30_mul(t2, 178956971 - q30_mul(t2,
            8947849 - q30_mul(t2, 213044))));
        cp = 1073741824 - q30_mul(t2, 536870912 - q30_mul(t2, 44739243 -
            q30_mul(t2, 1491308 - q30_mul(t2, 26631))));
        ss = (sp + 32768) >> 16;
        cc = (cp + 32768) >> 16;
        if ((m % 5760) > 2880) begin
            tmp = ss; ss = cc; cc = tmp;
        end
        case (q)
            0: begin s = ss; c = cc; end
            1: begin s = cc; c = -ss; end
            2: begin s = -ss; c = -cc; end
            default: begin s = -cc; c = ss; end
        endcase
    endfunction

    function automatic longint entry_q42(input longint v);
        return clip(round_shift(v, 28), -16384, 16384);
    endfunction

    function automatic void euler_matrix(input longint ax, ay, az, output longint m[9]);
        longint sx, cx, sy, cy, sz, cz, k;
        k = 16384;
        angle_trig(ax, sx, cx);
        angle_trig(ay, sy, cy);
        angle_trig(az, sz, cz);
        m[0] = entry_q42(cy * cz * k);
        m[1] = entry_q42(cz * sx * sy - cx * sz * k);
        m[2] = entry_q42(sx * sz * k + cx * cz * sy);
        m[3] = entry_q42(cy * sz * k);
        m[4] = entry_q42(cx * cz * k + sx * sy * sz);
        m[5] = entry_q42(cx * sy * sz - cz * sx * k);
        m[6] = entry_q42(-sy * k * k);
        m[7] = entry_q42(cy * sx * k);
        m[8] = entry_q42(cx * cy * k);
    endfunction

    function automatic t_out_word pose_transform(input t_in_word w, input logic [47:0] tang,
                                                 input logic [47:0] tpiv,
                                                 input logic [47:0] toff);
        longint r[9], tm[9], fm[9], t[3], ft[3], p[3], tp[3], off[3], acc, e;
        t_out_word o;
        for (int i = 0; i < 9; i++) fm[i] = (i % 4 == 0) ? 16384 : 0;
        ft = '{0, 0, 0};
        if (w.rotate_enable) begin
            euler_matrix(w.angle_x, w.angle_y, w.angle_z, r);
            p = '{w.pivot_x, w.pivot_y, w.pivot_z};
            for (int i = 0; i < 3; i++) begin
                acc = p[i] * 16384;
                for (int k = 0; k < 3; k++) acc -= r[i*3+k] * p[k];
                t[i] = clip(round_shift(acc, 14), -8388608, 8388607);
            end
            if (w.torso_enable) begin
                euler_matrix(longint'($signed(tang[15:0])), longint'($signed(tang[31:16])),
                             longint'($signed(tang[47:32])), tm);
                for (int i = 0; i < 3; i++) begin
                    tp[i] = longint'($signed(tpiv[16*i +: 16]));
                    off[i] = longint'($signed(toff[16*i +: 16]));
                end
                for (int i = 0; i < 3; i++) begin
                    acc = (tp[i] + off[i]) * 16384;
                    for (int j = 0; j < 3; j++) begin
                        e = 0;
                        for (int k = 0; k < 3; k++) e += tm[i*3+k] * r[k*3+j];
                        fm[i*3+j] = clip(round_shift(e, 14), -16384, 16384);
                    end
                    for (int k = 0; k < 3; k++) acc += tm[i*3+k] * (t[k] - tp[k]);
                    ft[i] = clip(round_shift(acc, 14), -8388608, 8388607);
                end
            end else begin
                fm = r;
                ft = t;
            end
        end
        o.m00 = 16'(fm[0]); o.m01 = 16'(fm[1]); o.m02 = 16'(fm[2]); o.move_x = 24'(ft[0]);
        o.m10 = 16'(fm[3]); o.m11 = 16'(fm[4]); o.m12 = 16'(fm[5]); o.move_y = 24'(ft[1]);
        o.m20 = 16'(fm[6]); o.m21 = 16'(fm[7]); o.m22 = 16'(fm[8]); o.move_z = 24'(ft[2]);
        return o;
    endfunction
endpackage

[tb/sv/testbench.sv]
// Testbench of the pose transform unit: random and directed poses, checked against
// a predictor in epct_tb_pkg. Depends on epct_pkg, the channel interfaces and the RTL.
`timescale 1ns / 1ps
module testbench;
    import epct_pkg::*;
    import epct_tb_pkg::*;

    localparam int N_RANDOM = 1800;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [47:0] i_cfg_data = '0;

    epct_in_if item_ch ();
    epct_out_if res_ch ();

    euler_pivot_transform_compose_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .o_res(res_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_word pose_queue[$];
    t_out_word transform_queue[$];
    logic [47:0] torso_ang = '0, torso_piv = '0, torso_off = '0;
    int mismatches = 0, words_sent = 0, words_checked = 0;
    longint cycles = 0;
    bit calm = 1'b0;
    int send_gap = 0, take_gap = 0, hold_off = 0;
    bit hold_req = 1'b0;

    initial begin
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch word %0d %s: got %0d expected %0d", words_checked, what, got, want);
        mismatches++;
    endtask

    // driver: offer pose words, with idle bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                transform_queue.insert(transform_queue.size(),
                                       pose_transform(item_ch.data, torso_ang,
                                                      torso_piv, torso_off));
                words_sent++;
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    item_ch.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    item_ch.valid <= 1'b0;
                end else if (pose_queue.size() > 0) begin
                    item_ch.data <= pose_queue.pop_front();
                    item_ch.valid <= 1'b1;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each transform word, with its own stalls
    always @(posedge i_clk) begin
        t_out_word g, x;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                g = res_ch.data;
                if (transform_queue.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    x = transform_queue.pop_front();
                    if (g.m00 !== x.m00) report("m00", g.m00, x.m00);
                    if (g.m01 !== x.m01) report("m01", g.m01, x.m01);
                    if (g.m02 !== x.m02) report("m02", g.m02, x.m02);
                    if (g.move_x !== x.move_x) report("move_x", g.move_x, x.move_x);
                    if (g.m10 !== x.m10) report("m10", g.m10, x.m10);
                    if (g.m11 !== x.m11) report("m11", g.m11, x.m11);
                    if (g.m12 !== x.m12) report("m12", g.m12, x.m12);
                    if (g.move_y !== x.move_y) report("move_y", g.move_y, x.move_y);
                    if (g.m20 !== x.m20) report("m20", g.m20, x.m20);
                    if (g.m21 !== x.m21) report("m21", g.m21, x.m21);
                    if (g.m22 !== x.m22) report("m22", g.m22, x.m22);
                    if (g.move_z !== x.move_z) report("move_z", g.move_z, x.move_z);
                end
                words_checked++;
            end
            if (hold_req && hold_off == 0) begin
                hold_off = 80;
                hold_req = 1'b0;
            end
            if (hold_off > 0) begin
                hold_off--;
                res_ch.ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                res_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                take_gap = $urandom_range(0, 3);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'(-23040);
            1: return 16'(23040);
            2: return 16'(2880 * $urandom_range(0, 15) - 23040);
            default: return 16'($urandom_range(0, 46080) - 23040);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 2047) - 1024);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_in_word random_pose();
        t_in_word w;
        w.rotate_enable = ($urandom_range(0, 9) != 0);
        w.angle_x = rand_angle();
        w.angle_y = rand_angle();
        w.angle_z = rand_angle();
        w.pivot_x = rand_coord();
        w.pivot_y = rand_coord();
        w.pivot_z = rand_coord();
        w.torso_enable = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic t_in_word pose(input bit re, input int ax, ay, az,
                                      input int px, py, pz, input bit te);
        t_in_word w;
        w = '{re, 16'(ax), 16'(ay), 16'(az), 16'(px), 16'(py), 16'(pz), te};
        return w;
    endfunction

    // append a pose word to the tail of the pending queue
    task automatic add_pose(input t_in_word w);
        pose_queue.insert(pose_queue.size(), w);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TORSO_ANGLES: torso_ang = val;
            CFG_TORSO_PIVOT: torso_piv = val;
            default: torso_off = val;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pose_queue.size() > 0 || item_ch.valid || transform_queue.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic torso_setting(input logic [47:0] a, p, o);
        write_reg(CFG_TORSO_ANGLES, a);
        write_reg(CFG_TORSO_PIVOT, p);
        write_reg(CFG_TORSO_OFFSET, o);
    endtask

    function automatic logic [47:0] rand_triple_angle();
        return {rand_angle(), rand_angle(), rand_angle()};
    endfunction

    function automatic logic [47:0] rand_triple_coord();
        return {rand_coord(), rand_coord(), rand_coord()};
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, quadrant edges, wrap, extreme pivots, torso
        add_pose(pose(0, 1000, -2000, 3000, 100, 200, 300, 1));
        add_pose(pose(1, 0, 0, 0, 0, 0, 0, 0));
        add_pose(pose(1, 5760, 0, 0, 256, 512, -256, 0));
        add_pose(pose(1, 0, 11520, 0, 256, 512, -256, 0));
        add_pose(pose(1, 0, 0, 17280, 256, 512, -256, 0));
        add_pose(pose(1, 2880, 2881, 2879, 1, -1, 1, 0));
        add_pose(pose(1, 23040, -23040, 23040, 0, 0, 0, 0));
        add_pose(pose(1, -23040, 23040, -5760, 32767, -32768, 32767, 0));
        add_pose(pose(1, 11520, 11520, 11520, -32768, -32768, -32768, 0));
        add_pose(pose(1, 3000, -7000, 9000, 32767, 32767, 32767, 1));
        add_pose(pose(1, 0, 0, 0, 0, 0, 0, 1));
        add_pose(pose(0, -1, -1, -1, -1, -1, -1, 0));
        drain();

        torso_setting({16'(5760), 16'(-11520), 16'(2880)}, {16'h7fff, 16'h8000, 16'h7fff},
                      {16'h7fff, 16'h7fff, 16'h8000});
        add_pose(pose(1, 5760, 5760, 5760, 32767, -32768, 32767, 1));
        add_pose(pose(1, -23040, 0, 23040, -32768, 32767, -32768, 1));
        add_pose(pose(1, 0, 0, 0, 0, 0, 0, 1));
        add_pose(pose(0, 0, 0, 0, 0, 0, 0, 1));
        drain();

        // random phases, each with a fresh torso setting
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) calm = 1'b1;
            if (ph == 0) torso_setting('0, '0, '0);
            else if (ph == 1) torso_setting('1, '1, '1);
            else torso_setting(rand_triple_angle(), rand_triple_coord(), rand_triple_coord());
            for (int n = 0; n < N_RANDOM / 6; n++) add_pose(random_pose());
            if (ph == 2) hold_req = 1'b1;
            drain();
        end

        $display("covered %0d pose words under several torso settings,", words_sent);
        $display("with identity, wrapped angles, extreme pivots and output back-pressure");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
